// File: rtl/core/sha1md_pkg.sv
package sha1md_pkg;

  // five 32-bit chaining words, index 0 is the most significant digest word
  typedef logic [0:4][31:0] chain_t;

  // standard initial hash values
  localparam chain_t H_INIT = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam int unsigned ROUNDS    = 80;
  localparam int unsigned RND_W     = 7;
  localparam logic [5:0]  LEN_FILL  = 6'd56;
  localparam logic [7:0]  PAD_MARK  = 8'h80;

  // round control from the sequencer
  typedef struct packed {
    logic             init;   // chain words back to initial values
    logic             load;   // working words take the chain words
    logic             step;   // one compression round
    logic             add;    // fold working words into the chain
    logic [RND_W-1:0] rnd;    // current round number
  } rnd_ctl_t;

  // message window control
  typedef struct packed {
    logic       byte_en;  // shift a message byte in
    logic [7:0] byte_val;
    logic       shift_en; // advance the schedule by one word
  } sched_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // round constant for each group of twenty rounds
  function automatic logic [31:0] round_k(input logic [RND_W-1:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5A82_7999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9_EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

endpackage

// File: rtl/core/sha1md_sched.sv
module sha1md_sched (
  input  logic                   clk,
  input  sha1md_pkg::sched_ctl_t ctl,
  output logic [31:0]            w_cur
);
  import sha1md_pkg::*;

  // sixteen-word window, word 0 at the top; bytes enter at the bottom
  logic [511:0] win_r;
  logic [511:0] win_nxt;
  logic [31:0]  w_new;

  // next schedule word from taps 0, 2, 8 and 13
  assign w_new = rotl(win_r[511-32*13 -: 32] ^ win_r[511-32*8 -: 32] ^
                      win_r[511-32*2 -: 32] ^ win_r[511 -: 32], 1);
  assign w_cur = win_r[511 -: 32];

  // window update
  always_comb begin
    win_nxt = win_r;
    if (ctl.byte_en) begin
      win_nxt = {win_r[503:0], ctl.byte_val};
    end else if (ctl.shift_en) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

// File: rtl/core/sha1md_round.sv
module sha1md_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1md_pkg::rnd_ctl_t ctl,
  input  logic [31:0]          w_cur,
  output sha1md_pkg::chain_t   chain
);
  import sha1md_pkg::*;

  chain_t      chain_r, chain_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] f;
  logic [31:0] t;

  assign chain = chain_r;

  // round function by group
  always_comb begin
    if (ctl.rnd inside {[7'd0:7'd19]}) begin
      f = (b_r & c_r) | (~b_r & d_r);
    end else if (ctl.rnd inside {[7'd40:7'd59]}) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    end else begin
      f = b_r ^ c_r ^ d_r;
    end
  end

  // shared round adder
  assign t = rotl(a_r, 5) + f + e_r + w_cur + round_k(ctl.rnd);

  // working and chain word update
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    chain_nxt = chain_r;
    if (ctl.load) begin
      a_nxt = chain_r[0];
      b_nxt = chain_r[1];
      c_nxt = chain_r[2];
      d_nxt = chain_r[3];
      e_nxt = chain_r[4];
    end else if (ctl.step) begin
      a_nxt = t;
      b_nxt = a_r;
      c_nxt = rotl(b_r, 30);
      d_nxt = c_r;
      e_nxt = d_r;
    end
    if (ctl.init) begin
      chain_nxt = H_INIT;
    end else if (ctl.add) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= H_INIT;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

endmodule

// File: rtl/core/sha1_message_digest.sv
// Byte-serial SHA-1 engine: a data request is taken in idle; one that fills a block
// starts 80 rounds on one shared round adder, then the chain add. A finish request
// pads 9 to 72 bytes, one byte per cycle outside compressions, runs one or two
// compressions, then offers five digest words, one per cycle while out_ready is high.
// Synchronous active-low reset restores the initial chain words and clears
// the fill count, bit count and overflow flag; the block buffer is not cleared.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word,
  output logic        out_too_long
);
  import sha1md_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // padding phases
  localparam logic [2:0] PS_NONE = 3'd0;
  localparam logic [2:0] PS_MARK = 3'd1;
  localparam logic [2:0] PS_ZERO = 3'd2;
  localparam logic [2:0] PS_LEN  = 3'd3;
  localparam logic [2:0] PS_DONE = 3'd4;

  localparam logic [2:0] LAST_WORD = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       pad_r, pad_nxt;
  logic [2:0]       len_idx_r, len_idx_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [63:0]      bitlen_r, bitlen_nxt;
  logic             flag_r, flag_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [2:0]       out_cnt_r, out_cnt_nxt;

  logic             push;
  logic [7:0]       push_byte;
  logic [64:0]      bitlen_sum;
  logic [7:0]       len_byte;
  rnd_ctl_t         rctl;
  sched_ctl_t       sctl;
  chain_t           chain;
  logic [31:0]      w_cur;

  assign bitlen_sum = {1'b0, bitlen_r} + 65'd8;
  assign len_byte   = bitlen_r[8*(7-len_idx_r) +: 8];

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    pad_nxt     = pad_r;
    len_idx_nxt = len_idx_r;
    fill_nxt    = fill_r;
    bitlen_nxt  = bitlen_r;
    flag_nxt    = flag_r;
    rnd_nxt     = rnd_r;
    out_cnt_nxt = out_cnt_r;
    push        = 1'b0;
    push_byte   = 8'h00;
    rctl        = '0;
    rctl.rnd    = rnd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            pad_nxt   = PS_MARK;
            state_nxt = ST_PAD;
          end else if (!flag_r) begin
            push       = 1'b1;
            push_byte  = in_data_byte;
            bitlen_nxt = bitlen_sum[63:0];
            flag_nxt   = bitlen_sum[64];
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        case (pad_r)
          PS_MARK: begin
            push_byte = PAD_MARK;
            pad_nxt   = PS_ZERO;
          end
          PS_ZERO: begin
            if (fill_r == LEN_FILL) begin
              push_byte   = len_byte;
              len_idx_nxt = 3'd1;
              pad_nxt     = PS_LEN;
            end
          end
          PS_LEN: begin
            push_byte   = len_byte;
            len_idx_nxt = len_idx_r + 3'd1;
            if (len_idx_r == 3'd7) begin
              pad_nxt = PS_DONE;
            end
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
      ST_COMP: begin
        rctl.step = 1'b1;
        rnd_nxt   = rnd_r + 1'b1;
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        rctl.add = 1'b1;
        rnd_nxt  = '0;
        if (pad_r == PS_NONE) begin
          state_nxt = ST_IDLE;
        end else if (pad_r == PS_DONE) begin
          out_cnt_nxt = '0;
          state_nxt   = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          out_cnt_nxt = out_cnt_r + 3'd1;
          if (out_cnt_r == LAST_WORD) begin
            rctl.init  = 1'b1;
            fill_nxt   = '0;
            bitlen_nxt = '0;
            flag_nxt   = 1'b0;
            pad_nxt    = PS_NONE;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // byte append, full block starts compression
    if (push) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        rctl.load = 1'b1;
        rnd_nxt   = '0;
        state_nxt = ST_COMP;
      end
    end
  end

  always_comb begin
    sctl.byte_en  = push;
    sctl.byte_val = push_byte;
    sctl.shift_en = (state_r == ST_COMP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pad_r     <= PS_NONE;
      len_idx_r <= '0;
      fill_r    <= '0;
      bitlen_r  <= '0;
      flag_r    <= 1'b0;
      rnd_r     <= '0;
      out_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pad_r     <= pad_nxt;
      len_idx_r <= len_idx_nxt;
      fill_r    <= fill_nxt;
      bitlen_r  <= bitlen_nxt;
      flag_r    <= flag_nxt;
      rnd_r     <= rnd_nxt;
      out_cnt_r <= out_cnt_nxt;
    end
  end

  sha1md_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_cur (w_cur)
  );

  sha1md_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .w_cur (w_cur),
    .chain (chain)
  );

  // handshake and result fields
  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = chain[out_cnt_r];
  assign out_word_number = out_cnt_r;
  assign out_last_word   = (out_cnt_r == LAST_WORD);
  assign out_too_long    = flag_r;

  // no request taken while a digest is offered
  assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && in_ready))
    else $error("input ready while digest offered");

  // round counter stays within the compression
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP) |-> (rnd_r < RND_W'(ROUNDS)))
    else $error("round counter out of range");

  // last digest word returns the engine to idle with a fresh state
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=>
      (in_ready && fill_r == 6'd0 && !flag_r && bitlen_r == 64'd0))
    else $error("engine not reinitialized after digest");

  // word number stays within the digest while offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_number <= LAST_WORD))
    else $error("digest word number out of range");

  // compression ends in the chain add
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && rnd_r == RND_W'(ROUNDS - 1)) |=> (state_r == ST_ADD))
    else $error("compression did not end in chain add");

endmodule

// File: tb/sha1_tb_pkg.sv
package sha1_tb_pkg;

  // request kinds on the input channel
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

endpackage

// File: tb/sha1_digest_checker.sv
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_number,
  input  logic        out_last_word,
  input  logic        out_too_long,
  output int          mismatch_count,
  output int          words_pending,
  output int          words_checked
);
  import sha1md_pkg::*;
  import sha1_tb_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
    logic        too_long;
  } digest_word_t;

  // digest words still owed by the block, oldest first
  digest_word_t digest_words_due [$];

  // shadow of the hash state
  logic [7:0]  msg_block [0:63];
  logic [6:0]  fill_level;
  logic [63:0] msg_bits;
  chain_t      chain_h;
  logic        length_wrapped;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] stage_const(input int unsigned r);
    logic [31:0] k;
    if (r < 20) begin
      k = 32'h5A82_7999;
    end else if (r < 40) begin
      k = 32'h6ED9_EBA1;
    end else if (r < 60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

  // 80-round compression of the full block into the chain
  task automatic fold_block();
    logic [31:0] w [0:79];
    logic [31:0] a, b, c, d, e, f, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
      end else if (i < 40 || i >= 60) begin
        f = b ^ c ^ d;
      end else begin
        f = (b & c) | (b & d) | (c & d);
      end
      t = rol32(a, 5) + f + e + w[i] + stage_const(i);
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
    fill_level = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    msg_block[fill_level[5:0]] = v;
    fill_level = fill_level + 7'd1;
    if (fill_level == 7'd64) begin
      fold_block();
    end
  endtask

  task automatic restart_message();
    fill_level     = '0;
    msg_bits       = '0;
    chain_h        = H_INIT;
    length_wrapped = 1'b0;
  endtask

  // pad, append the bit length and queue the five digest words
  task automatic close_message();
    digest_word_t dw;
    absorb_byte(PAD_MARK);
    while (fill_level != {1'b0, LEN_FILL}) begin
      absorb_byte(8'h00);
    end
    for (int i = 0; i < 8; i++) begin
      absorb_byte(msg_bits[63-8*i -: 8]);
    end
    for (int k = 0; k < 5; k++) begin
      dw.word     = chain_h[k];
      dw.num      = k[2:0];
      dw.last     = (k == 4);
      dw.too_long = length_wrapped;
      digest_words_due.push_back(dw);
    end
    restart_message();
  endtask

  always @(posedge clk) begin : track
    digest_word_t want;
    logic [63:0]  prev_bits;
    if (!rst_n) begin
      restart_message();
      digest_words_due.delete();
    end else begin
      // compare a delivered digest word with the oldest one owed
      if (out_valid && out_ready) begin
        if (digest_words_due.size() == 0) begin
          $error("unexpected digest word %h (word_number %0d)", out_digest_word,
                 out_word_number);
          mismatch_count++;
        end else begin
          want = digest_words_due.pop_front();
          words_checked++;
          if (out_digest_word !== want.word) begin
            $error("digest_word mismatch: expected %h, actual %h", want.word,
                   out_digest_word);
            mismatch_count++;
          end
          if (out_word_number !== want.num) begin
            $error("word_number mismatch: expected %0d, actual %0d", want.num,
                   out_word_number);
            mismatch_count++;
          end
          if (out_last_word !== want.last) begin
            $error("last_word mismatch: expected %b, actual %b", want.last,
                   out_last_word);
            mismatch_count++;
          end
          if (out_too_long !== want.too_long) begin
            $error("too_long mismatch: expected %b, actual %b", want.too_long,
                   out_too_long);
            mismatch_count++;
          end
        end
      end
      // advance the shadow state on each accepted request
      if (in_valid && in_ready) begin
        if (in_kind == KIND_DATA) begin
          if (!length_wrapped) begin
            prev_bits = msg_bits;
            msg_bits  = msg_bits + 64'd8;
            absorb_byte(in_data_byte);
            if (msg_bits < prev_bits) begin
              length_wrapped = 1'b1;
            end
          end
        end else begin
          close_message();
        end
      end
    end
    words_pending = digest_words_due.size();
  end

endmodule

// File: tb/tb_sha1_message_digest.sv
module tb_sha1_message_digest;
  import sha1_tb_pkg::*;

  localparam int ITEM_TARGET  = 250;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_last_word;
  logic        out_too_long;

  logic calm;
  int   requests_sent;
  int   messages_sent;
  int   bytes_sent;
  int   mismatch_count;
  int   words_pending;
  int   words_checked;

  sha1_message_digest dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_number (out_word_number),
    .out_last_word   (out_last_word),
    .out_too_long    (out_too_long)
  );

  sha1_digest_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_number (out_word_number),
    .out_last_word   (out_last_word),
    .out_too_long    (out_too_long),
    .mismatch_count  (mismatch_count),
    .words_pending   (words_pending),
    .words_checked   (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stalls at random except during the calm stretch
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 38);
  end

  // give up after too many cycles with no request or digest word moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic k, input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid     <= 1'b0;
      in_kind      <= 1'($urandom);
      in_data_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (k == KIND_FINISH) begin
      messages_sent++;
    end else begin
      bytes_sent++;
    end
  endtask

  // style 0 random bytes, 1 all zeros, 2 all ones
  task automatic send_message(input int len, input int style);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (style)
        1: begin
          b = 8'h00;
        end
        2: begin
          b = 8'hFF;
        end
        default: begin
          b = 8'($urandom);
        end
      endcase
      send_request(KIND_DATA, b);
    end
    send_request(KIND_FINISH, 8'($urandom));
  endtask

  // hold the sender back until every digest word has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int msg_idx;
    int len;
    in_valid      = 1'b0;
    in_kind       = KIND_DATA;
    in_data_byte  = 8'h00;
    calm          = 1'b0;
    requests_sent = 0;
    messages_sent = 0;
    bytes_sent    = 0;
    rst_n         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty message, the byte on the finish request is ignored
    send_request(KIND_FINISH, 8'hFF);
    // "abc"
    send_request(KIND_DATA, 8'h61);
    send_request(KIND_DATA, 8'h62);
    send_request(KIND_DATA, 8'h63);
    send_request(KIND_FINISH, 8'h00);
    // byte extremes and the pad marker value as data
    send_request(KIND_DATA, 8'h00);
    send_request(KIND_DATA, 8'hFF);
    send_request(KIND_DATA, 8'h80);
    send_request(KIND_DATA, 8'h7F);
    send_request(KIND_FINISH, 8'h80);
    wait_drained();

    // random messages, lengths biased toward the padding boundaries
    msg_idx = 0;
    while (requests_sent < ITEM_TARGET) begin
      calm = (msg_idx >= 3 && msg_idx < 6);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          len = $urandom_range(24);
        end
        6, 7, 8: begin
          case ($urandom_range(4))
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            default: len = 65;
          endcase
        end
        default: begin
          len = $urandom_range(130, 100);
        end
      endcase
      // keep the total close to the request budget
      if (len > ITEM_TARGET - requests_sent - 1) begin
        len = ITEM_TARGET - requests_sent - 1;
      end
      send_message(len, ($urandom_range(5) == 0) ? $urandom_range(2, 1) : 0);
      if (msg_idx % 4 == 3) begin
        wait_drained();
      end
      msg_idx++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d requests: %0d messages with %0d data bytes in total",
             requests_sent, messages_sent, bytes_sent);
    $display("compared %0d digest words, %0d mismatches", words_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
